// ===== hw/rtl/selective_color_keep_filter_assert.svh =====
// Assertion macros for the selective color keep filter.
`ifndef SELECTIVE_COLOR_KEEP_FILTER_ASSERT_SVH
`define SELECTIVE_COLOR_KEEP_FILTER_ASSERT_SVH

`ifndef SYNTH
// Whenever pre holds, post must hold in the same cycle.
`define SCC_ASSERT_IMPLY(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("implication check failed");
// The condition must never hold.
`define SCC_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define SCC_ASSERT_IMPLY(lbl, pre, post)
`define SCC_ASSERT_NEVER(lbl, cond)
`endif

`endif

// ===== hw/rtl/scc_pkg.sv =====
// Shared types and constants of the selective color keep filter.
package scc_pkg;

  localparam int CH_W              = 8;
  localparam int RAD_W             = 10;
  localparam int K_W               = 20;
  localparam int CFG_IDX_W         = 3;
  localparam int FRACTION_BITS_DEF = 16;

  typedef struct packed {
    logic [CH_W-1:0] in_alpha;
    logic [CH_W-1:0] in_red;
    logic [CH_W-1:0] in_green;
    logic [CH_W-1:0] in_blue;
  } in_pix_t;

  typedef struct packed {
    logic [CH_W-1:0] out_alpha;
    logic [CH_W-1:0] out_red;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_blue;
  } out_pix_t;

  typedef struct packed {
    logic [CH_W-1:0]  key_red;
    logic [CH_W-1:0]  key_green;
    logic [CH_W-1:0]  key_blue;
    logic [RAD_W-1:0] keep_radius;
    logic             soft_mode;
    logic             bypass;
  } cfg_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_RED     = 3'd0,
    REG_KEY_GREEN   = 3'd1,
    REG_KEY_BLUE    = 3'd2,
    REG_KEEP_RADIUS = 3'd3,
    REG_SOFT_MODE   = 3'd4,
    REG_BYPASS      = 3'd5
  } cfg_reg_t;

  // What the last stage does with a pixel.
  typedef enum logic [1:0] {
    SEL_PASS  = 2'd0,
    SEL_GRAY  = 2'd1,
    SEL_BLEND = 2'd2
  } sel_t;

  // Per-item data that rides alongside the arithmetic.
  typedef struct packed {
    in_pix_t         pix;
    logic [CH_W-1:0] gray;
    sel_t            sel;
  } side_t;

endpackage

// ===== hw/rtl/selective_color_keep_filter.sv =====
// Top level of the selective color keep filter pipeline.
//
//   Channel   Ports                                   Handshake
//   input     in_valid, in_ready, in_data             valid/ready, one ARGB item
//   output    out_valid, out_ready, out_data          valid/ready, one ARGB item
//   config    cfg_we, cfg_index, cfg_wdata            write enable, no wait
//
// One item is accepted per clock while the output is not blocked. The square
// root and the division each retire one result bit per pipeline stage.
// Reset is synchronous and active low; it empties the pipeline and loads the
// register defaults (radius one, everything else zero).
// A stage holds its item only when the stage after it is full and holding, so
// bubbles close up and a blocked output stalls the input only once every
// stage is occupied.
module selective_color_keep_filter #(
  parameter int FRACTION_BITS = scc_pkg::FRACTION_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  scc_pkg::in_pix_t              in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output scc_pkg::out_pix_t             out_data,
  input  logic                          cfg_we,
  input  logic [scc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [scc_pkg::RAD_W-1:0]     cfg_wdata
);
  import scc_pkg::*;

`include "selective_color_keep_filter_assert.svh"

  // Root width: ten integer bits from k plus the fraction bits.
  localparam int SQ_W  = K_W / 2 + FRACTION_BITS;
  localparam int REM_W = SQ_W + 2;
  localparam logic [SQ_W-1:0] P_ONE = SQ_W'(1) << FRACTION_BITS;

  // Configuration registers. The user must write them only while the pipeline is
  // empty, as every stage reads them directly; the block does not enforce this.
  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_KEY_RED:     cfg_nxt.key_red     = cfg_wdata[CH_W-1:0];
        REG_KEY_GREEN:   cfg_nxt.key_green   = cfg_wdata[CH_W-1:0];
        REG_KEY_BLUE:    cfg_nxt.key_blue    = cfg_wdata[CH_W-1:0];
        REG_KEEP_RADIUS: cfg_nxt.keep_radius = cfg_wdata;
        REG_SOFT_MODE:   cfg_nxt.soft_mode   = cfg_wdata[0];
        REG_BYPASS:      cfg_nxt.bypass      = cfg_wdata[0];
        default:         cfg_nxt             = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{key_red: '0, key_green: '0, key_blue: '0, keep_radius: RAD_W'(1),
                 soft_mode: 1'b0, bypass: 1'b0};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Square root chain; index 0 is the output of the front stages.
  logic  [SQ_W:0]             sq_vld, sq_rdy;
  logic  [SQ_W:0][K_W-1:0]    sq_k;
  logic  [SQ_W:0][REM_W-1:0]  sq_rem;
  logic  [SQ_W:0][SQ_W-1:0]   sq_root;
  side_t [SQ_W:0]             sq_side;

  // Division chain; index 0 takes the finished root.
  logic  [SQ_W:0]             dv_vld, dv_rdy;
  logic  [SQ_W:0][SQ_W-1:0]   dv_num;
  logic  [SQ_W:0][RAD_W-1:0]  dv_rem;
  side_t [SQ_W:0]             dv_side;

  scc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .up_pix   (in_data),
    .dn_valid (sq_vld[0]),
    .dn_ready (sq_rdy[0]),
    .dn_k     (sq_k[0]),
    .dn_side  (sq_side[0])
  );

  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;

  for (genvar i = 0; i < SQ_W; i++) begin : g_sqrt
    scc_sqrt_step #(
      .SQ_W (SQ_W)
    ) u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (sq_vld[i]),
      .up_ready (sq_rdy[i]),
      .up_k     (sq_k[i]),
      .up_rem   (sq_rem[i]),
      .up_root  (sq_root[i]),
      .up_side  (sq_side[i]),
      .dn_valid (sq_vld[i+1]),
      .dn_ready (sq_rdy[i+1]),
      .dn_k     (sq_k[i+1]),
      .dn_rem   (sq_rem[i+1]),
      .dn_root  (sq_root[i+1]),
      .dn_side  (sq_side[i+1])
    );
  end

  assign dv_vld[0]      = sq_vld[SQ_W];
  assign sq_rdy[SQ_W]   = dv_rdy[0];
  assign dv_num[0]      = sq_root[SQ_W];
  assign dv_rem[0]      = '0;
  assign dv_side[0]     = sq_side[SQ_W];

  for (genvar i = 0; i < SQ_W; i++) begin : g_div
    scc_div_step #(
      .SQ_W (SQ_W)
    ) u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .radius   (cfg_r.keep_radius),
      .up_valid (dv_vld[i]),
      .up_ready (dv_rdy[i]),
      .up_num   (dv_num[i]),
      .up_rem   (dv_rem[i]),
      .up_side  (dv_side[i]),
      .dn_valid (dv_vld[i+1]),
      .dn_ready (dv_rdy[i+1]),
      .dn_num   (dv_num[i+1]),
      .dn_rem   (dv_rem[i+1]),
      .dn_side  (dv_side[i+1])
    );
  end

  // The quotient never exceeds one for a blended pixel, so its low
  // FRACTION_BITS + 1 bits carry the whole blend factor.
  scc_blend #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_blend (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (dv_vld[SQ_W]),
    .up_ready (dv_rdy[SQ_W]),
    .up_p     (dv_num[SQ_W][FRACTION_BITS:0]),
    .up_side  (dv_side[SQ_W]),
    .dn_valid (out_valid),
    .dn_ready (out_ready),
    .dn_pix   (out_data)
  );

  // The input only backs up when the output register is full and blocked.
  `SCC_ASSERT_IMPLY(a_stall_from_output, !in_ready, out_valid && !out_ready)
  // A blended pixel never gets a factor above one.
  `SCC_ASSERT_IMPLY(a_blend_factor_le_one, dv_vld[SQ_W] && dv_side[SQ_W].sel == SEL_BLEND,
                    dv_num[SQ_W] <= P_ONE)
  // The division remainder stays below a nonzero divisor.
  `SCC_ASSERT_NEVER(a_div_rem_bound,
                    dv_vld[SQ_W] && cfg_r.keep_radius != '0 && dv_rem[SQ_W] >= cfg_r.keep_radius)

endmodule

// ===== hw/rtl/scc_front.sv =====
// Front stages: squared distance, gray level and keep decision.
module scc_front (
  input  logic           clk,
  input  logic           rst_n,
  input  scc_pkg::cfg_t  cfg,
  input  logic           up_valid,
  output logic           up_ready,
  input  scc_pkg::in_pix_t up_pix,
  output logic           dn_valid,
  input  logic           dn_ready,
  output logic [scc_pkg::K_W-1:0] dn_k,
  output scc_pkg::side_t dn_side
);
  import scc_pkg::*;

  localparam int SQ_W   = 2 * CH_W;
  localparam int GSUM_W = CH_W + 5;

  logic                va_r;
  logic                a_ready;
  in_pix_t             pix_a_r;
  logic [SQ_W-1:0]     sqr_a_r, sqg_a_r, sqb_a_r;
  logic [SQ_W-1:0]     sqr_nxt, sqg_nxt, sqb_nxt;
  logic [CH_W-1:0]     gray_a_r, gray_nxt;
  logic [2*RAD_W-1:0]  rad2_a_r, rad2_nxt;
  logic [CH_W-1:0]     dr, dg, db;
  logic [GSUM_W-1:0]   gsum;

  logic                vb_r;
  logic [K_W-1:0]      k_b_r, k_nxt;
  side_t               side_b_r, side_nxt;

  function automatic logic [CH_W-1:0] absdiff(input logic [CH_W-1:0] a,
                                               input logic [CH_W-1:0] b);
    absdiff = (a >= b) ? a - b : b - a;
  endfunction

  // Stage A: channel distances squared, gray sum, radius squared.
  always_comb begin
    dr       = absdiff(up_pix.in_red,   cfg.key_red);
    dg       = absdiff(up_pix.in_green, cfg.key_green);
    db       = absdiff(up_pix.in_blue,  cfg.key_blue);
    sqr_nxt  = SQ_W'(dr) * SQ_W'(dr);
    sqg_nxt  = SQ_W'(dg) * SQ_W'(dg);
    sqb_nxt  = SQ_W'(db) * SQ_W'(db);
    gsum     = GSUM_W'(11) * GSUM_W'(up_pix.in_red) + GSUM_W'(16) * GSUM_W'(up_pix.in_green)
             + GSUM_W'(5) * GSUM_W'(up_pix.in_blue);
    gray_nxt = gsum[GSUM_W-1:5];
    rad2_nxt = (2*RAD_W)'(cfg.keep_radius) * (2*RAD_W)'(cfg.keep_radius);
  end

  assign up_ready = ~va_r | a_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (up_ready) begin
      va_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      pix_a_r  <= up_pix;
      sqr_a_r  <= sqr_nxt;
      sqg_a_r  <= sqg_nxt;
      sqb_a_r  <= sqb_nxt;
      gray_a_r <= gray_nxt;
      rad2_a_r <= rad2_nxt;
    end
  end

  // Stage B: total distance and the keep decision.
  always_comb begin
    k_nxt         = K_W'(sqr_a_r) + K_W'(sqg_a_r) + K_W'(sqb_a_r);
    side_nxt.pix  = pix_a_r;
    side_nxt.gray = gray_a_r;
    priority if (cfg.bypass) begin
      side_nxt.sel = SEL_PASS;
    end else if (k_nxt > rad2_a_r) begin
      side_nxt.sel = SEL_GRAY;
    end else if (cfg.soft_mode && (cfg.keep_radius != '0)) begin
      side_nxt.sel = SEL_BLEND;
    end else begin
      side_nxt.sel = SEL_PASS;
    end
  end

  assign a_ready = ~vb_r | dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (a_ready) begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && va_r) begin
      k_b_r    <= k_nxt;
      side_b_r <= side_nxt;
    end
  end

  assign dn_valid = vb_r;
  assign dn_k     = k_b_r;
  assign dn_side  = side_b_r;

endmodule

// ===== hw/rtl/scc_sqrt_step.sv =====
// One digit step of the bitwise fixed-point square root.
module scc_sqrt_step #(
  parameter int SQ_W = 26
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    up_valid,
  output logic                    up_ready,
  input  logic [scc_pkg::K_W-1:0] up_k,
  input  logic [SQ_W+1:0]         up_rem,
  input  logic [SQ_W-1:0]         up_root,
  input  scc_pkg::side_t          up_side,
  output logic                    dn_valid,
  input  logic                    dn_ready,
  output logic [scc_pkg::K_W-1:0] dn_k,
  output logic [SQ_W+1:0]         dn_rem,
  output logic [SQ_W-1:0]         dn_root,
  output scc_pkg::side_t          dn_side
);
  import scc_pkg::*;

  localparam int REM_W = SQ_W + 2;

  logic             v_r;
  logic [K_W-1:0]   k_r, k_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt, rem_sh, trial;
  logic [SQ_W-1:0]  root_r, root_nxt;
  side_t            side_r;

  // Bring down the next bit pair of k; k is shifted so the pair is always on top.
  always_comb begin
    rem_sh = {up_rem[REM_W-3:0], up_k[K_W-1:K_W-2]};
    trial  = {up_root, 2'b01};
    k_nxt  = {up_k[K_W-3:0], 2'b00};
    if (rem_sh >= trial) begin
      rem_nxt  = rem_sh - trial;
      root_nxt = {up_root[SQ_W-2:0], 1'b1};
    end else begin
      rem_nxt  = rem_sh;
      root_nxt = {up_root[SQ_W-2:0], 1'b0};
    end
  end

  assign up_ready = ~v_r | dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      k_r    <= k_nxt;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      side_r <= up_side;
    end
  end

  assign dn_valid = v_r;
  assign dn_k     = k_r;
  assign dn_rem   = rem_r;
  assign dn_root  = root_r;
  assign dn_side  = side_r;

endmodule

// ===== hw/rtl/scc_div_step.sv =====
// One quotient bit of the restoring division of the root by the radius.
module scc_div_step #(
  parameter int SQ_W = 26
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [scc_pkg::RAD_W-1:0] radius,
  input  logic                      up_valid,
  output logic                      up_ready,
  input  logic [SQ_W-1:0]           up_num,
  input  logic [scc_pkg::RAD_W-1:0] up_rem,
  input  scc_pkg::side_t            up_side,
  output logic                      dn_valid,
  input  logic                      dn_ready,
  output logic [SQ_W-1:0]           dn_num,
  output logic [scc_pkg::RAD_W-1:0] dn_rem,
  output scc_pkg::side_t            dn_side
);
  import scc_pkg::*;

  logic             v_r;
  logic [SQ_W-1:0]  num_r, num_nxt;
  logic [RAD_W-1:0] rem_r, rem_nxt;
  logic [RAD_W:0]   rem_sh, rem_sub;
  logic             ge;
  side_t            side_r;

  // The dividend shifts out at the top while quotient bits shift in below.
  always_comb begin
    rem_sh  = {up_rem, up_num[SQ_W-1]};
    rem_sub = rem_sh - {1'b0, radius};
    ge      = (rem_sh >= {1'b0, radius});
    rem_nxt = ge ? rem_sub[RAD_W-1:0] : rem_sh[RAD_W-1:0];
    num_nxt = {up_num[SQ_W-2:0], ge};
  end

  assign up_ready = ~v_r | dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      num_r  <= num_nxt;
      rem_r  <= rem_nxt;
      side_r <= up_side;
    end
  end

  assign dn_valid = v_r;
  assign dn_num   = num_r;
  assign dn_rem   = rem_r;
  assign dn_side  = side_r;

endmodule

// ===== hw/rtl/scc_blend.sv =====
// Blend toward gray: product stage, then the result and output register.
module scc_blend #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  logic [FRACTION_BITS:0] up_p,
  input  scc_pkg::side_t       up_side,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output scc_pkg::out_pix_t    dn_pix
);
  import scc_pkg::*;

  localparam int PROD_W = FRACTION_BITS + 1 + CH_W;
  localparam int RES_W  = CH_W + 2;

  logic                         v1_r;
  logic                         s1_ready;
  logic [2:0][CH_W-1:0]         chan_in, chan_1;
  logic [2:0][CH_W-1:0]         chan_dist;
  logic [2:0]                   neg_nxt, neg_r;
  logic [2:0][PROD_W-1:0]       prod_nxt, prod_r;
  side_t                        side_r;

  logic                         v2_r;
  logic [2:0][CH_W-1:0]         res_nxt, res_r;
  logic [2:0][RES_W-1:0]        step_w, res_w;
  logic [2:0]                   frac_nz;
  logic [CH_W-1:0]              alpha_r;

  // Stage 1: p times the distance of each channel to gray.
  always_comb begin
    chan_in = {up_side.pix.in_red, up_side.pix.in_green, up_side.pix.in_blue};
    for (int i = 0; i < 3; i++) begin
      neg_nxt[i]   = (up_side.gray < chan_in[i]);
      chan_dist[i] = neg_nxt[i] ? chan_in[i] - up_side.gray : up_side.gray - chan_in[i];
      prod_nxt[i]  = PROD_W'(up_p) * PROD_W'(chan_dist[i]);
    end
  end

  assign up_ready = ~v1_r | s1_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (up_ready) begin
      v1_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      prod_r <= prod_nxt;
      neg_r  <= neg_nxt;
      side_r <= up_side;
    end
  end

  // Stage 2: floor toward gray when rising, ceiling of the step when falling.
  always_comb begin
    chan_1 = {side_r.pix.in_red, side_r.pix.in_green, side_r.pix.in_blue};
    for (int i = 0; i < 3; i++) begin
      frac_nz[i] = |prod_r[i][FRACTION_BITS-1:0];
      step_w[i]  = RES_W'(prod_r[i][PROD_W-1:FRACTION_BITS]) + RES_W'(neg_r[i] & frac_nz[i]);
      res_w[i]   = neg_r[i] ? RES_W'(chan_1[i]) - step_w[i] : RES_W'(chan_1[i]) + step_w[i];
      unique case (side_r.sel)
        SEL_GRAY:  res_nxt[i] = side_r.gray;
        SEL_BLEND: res_nxt[i] = res_w[i][CH_W-1:0];
        default:   res_nxt[i] = chan_1[i];
      endcase
    end
  end

  assign s1_ready = ~v2_r | dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (s1_ready) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && v1_r) begin
      res_r   <= res_nxt;
      alpha_r <= side_r.pix.in_alpha;
    end
  end

  assign dn_valid         = v2_r;
  assign dn_pix.out_alpha = alpha_r;
  assign dn_pix.out_red   = res_r[2];
  assign dn_pix.out_green = res_r[1];
  assign dn_pix.out_blue  = res_r[0];

endmodule
